// ===== hdl/fpcm_pkg.sv =====
package fpcm_pkg;

  localparam logic [2:0] FMT_FLOAT   = 3'd0;
  localparam logic [2:0] FMT_INT16   = 3'd1;
  localparam logic [2:0] FMT_INT24   = 3'd2;
  localparam logic [2:0] FMT_INT24HI = 3'd3;
  localparam logic [2:0] FMT_INT32   = 3'd4;

  // Decoded sample, passed from the front stage to the scaling stage
  typedef struct packed {
    logic        sat;      // NaN or magnitude >= 1
    logic        neg;
    logic        nan;
    logic [23:0] mant;
    logic [7:0]  sh;       // right shift of mant*maxpos
    logic [2:0]  fmt;
    logic [31:0] raw;
  } dec_t;

endpackage

// ===== hdl/fpcm_decode.sv =====
module fpcm_decode (
  input  logic [31:0]         sample_bits,
  input  logic [2:0]          output_format,
  output fpcm_pkg::dec_t      dec
);
  logic [7:0]  ex;
  logic [22:0] fr;

  assign ex = sample_bits[30:23];
  assign fr = sample_bits[22:0];

  always_comb begin
    dec.nan  = (ex == 8'hFF) && (fr != 23'd0);
    dec.sat  = (ex >= 8'd127);
    dec.neg  = sample_bits[31];
    dec.mant = (ex != 8'd0) ? {1'b1, fr} : {1'b0, fr};
    dec.sh   = (ex != 8'd0) ? (8'd150 - ex) : 8'd149;
    dec.fmt  = output_format;
    dec.raw  = sample_bits;
  end
endmodule

// ===== hdl/fpcm_scale.sv =====
module fpcm_scale (
  input  fpcm_pkg::dec_t dec,
  output logic [31:0]    word
);
  logic [30:0] maxpos;
  logic [54:0] prod;
  logic [55:0] rnd;
  logic [31:0] q;
  logic [31:0] code;
  logic [31:0] negmin;
  logic [5:0]  n;

  always_comb begin
    case (dec.fmt)
      fpcm_pkg::FMT_INT16: n = 6'd16;
      fpcm_pkg::FMT_INT24, fpcm_pkg::FMT_INT24HI: n = 6'd24;
      default: n = 6'd32;
    endcase
    maxpos = 31'((32'd1 << (n - 6'd1)) - 32'd1);
    negmin = 32'd0 - (32'd1 << (n - 6'd1));
    // maxpos is 2^(n-1)-1: shift-and-subtract instead of a multiplier
    prod = (55'(dec.mant) << (n - 6'd1)) - 55'(dec.mant);
    if (dec.sh > 8'd62) begin
      rnd = 56'd0;
      q = 32'd0;
    end else begin
      rnd = {1'b0, prod} + (56'd1 << (dec.sh - 8'd1));
      q = 32'(rnd >> dec.sh);
    end
    if (dec.nan) begin
      code = 32'(maxpos);
    end else if (dec.sat) begin
      code = dec.neg ? negmin : 32'(maxpos);
    end else begin
      code = dec.neg ? (32'd0 - q) : q;
    end
    case (dec.fmt)
      fpcm_pkg::FMT_FLOAT:   word = dec.raw;
      fpcm_pkg::FMT_INT16:   word = {16'd0, code[15:0]};
      fpcm_pkg::FMT_INT24:   word = {8'd0, code[23:0]};
      fpcm_pkg::FMT_INT24HI: word = {code[23:0], 8'd0};
      default:               word = code;
    endcase
  end
endmodule

// ===== hdl/float_to_pcm_sample_converter.sv =====
// Float sample to PCM container converter.
// Input channel: in_valid/in_ready with sample_bits (IEEE-754 single).
// Output channel: out_valid/out_ready with pcm_word.
// cfg_we/cfg_data write output_format (0 float, 1 int16, 2 packed int24,
// 3 int24 left-justified in 32, 4 int32); write only while idle.
// Two register stages: input register (decode follows it), result
// register after scaling. An accepted item is decoded and scaled from
// the input register and captured in the result register with out_valid;
// one item per cycle is sustained while out_ready is held high.
// Each stage advances when its downstream slot is empty or being taken,
// so a stalled receiver backs up through both stages, then drops in_ready.
// Reset clears both valid flags and sets the format to float passthrough.
module float_to_pcm_sample_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pcm_word
);
  logic [2:0]     output_format;
  logic [31:0]    in_reg;
  logic           in_full;
  fpcm_pkg::dec_t dec;
  logic [31:0]    word;
  logic           adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format <= fpcm_pkg::FMT_FLOAT;
    end else if (cfg_we) begin
      output_format <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (adv) out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= sample_bits;
    if (adv && in_full) pcm_word <= word;
  end

  fpcm_decode u_dec (
    .sample_bits  (in_reg),
    .output_format(output_format),
    .dec          (dec)
  );

  fpcm_scale u_scale (
    .dec (dec),
    .word(word)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pcm_word))
    else $error("result changed while stalled");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_full && adv |=> out_valid)
    else $error("item lost between stages");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("in_ready low without backpressure");
endmodule
